FILE: design/rhsv_pkg.sv
// Shared types, constants and the divider step for the RGB to HSV converter.
// No dependencies.
package rhsv_pkg;

   localparam int unsigned CHAN_W = 8;
   localparam int unsigned QUO_W = 8;
   localparam int unsigned NUM_CELLS = QUO_W;
   localparam int unsigned REM_W = 2 * CHAN_W;
   localparam int unsigned DVS_W = CHAN_W + QUO_W - 1;

   localparam logic [CHAN_W-1:0] HUE_STEP = 8'd43;
   localparam logic [CHAN_W-1:0] BASE_RED = 8'd0;
   localparam logic [CHAN_W-1:0] BASE_GREEN = 8'd85;
   localparam logic [CHAN_W-1:0] BASE_BLUE = 8'd171;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [DVS_W-1:0] dvs;
      logic [QUO_W-1:0] quo;
   } rhsv_div_type;

   typedef struct packed {
      rhsv_div_type sat;
      rhsv_div_type hue;
      logic [CHAN_W-1:0] base;
      logic neg;
      logic grey;
      logic [CHAN_W-1:0] brightness;
   } rhsv_work_type;

   // one restoring step: try the shifted divisor, record a quotient bit
   function automatic rhsv_div_type rhsv_div_step(rhsv_div_type d);
      rhsv_div_type r;
      logic [REM_W-1:0] dvs_ext;
      dvs_ext = {1'b0, d.dvs};
      r = d;
      r.dvs = d.dvs >> 1;
      if (d.rem >= dvs_ext) begin
         r.rem = d.rem - dvs_ext;
         r.quo = {d.quo[QUO_W-2:0], 1'b1};
      end else begin
         r.quo = {d.quo[QUO_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

FILE: design/rhsv_front.sv
// Input stage: max/min, sector pick and divider operand setup, registered.
// Depends on rhsv_pkg.
module rhsv_front (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [rhsv_pkg::CHAN_W-1:0] red,
   input  logic [rhsv_pkg::CHAN_W-1:0] green,
   input  logic [rhsv_pkg::CHAN_W-1:0] blue,
   output logic out_valid,
   input  logic out_ready,
   output rhsv_pkg::rhsv_work_type out_data
);
   import rhsv_pkg::*;

   logic valid_ff;
   rhsv_work_type data_ff, data_in;
   logic [CHAN_W-1:0] mx, mn, spread, p, n, d, base;
   logic neg;
   logic [13:0] hue_num;

   always_comb begin
      mx = (red > green) ? red : green;
      if (blue > mx) mx = blue;
      mn = (red < green) ? red : green;
      if (blue < mn) mn = blue;
      spread = mx - mn;
      if (red == mx) begin
         p = green; n = blue; base = BASE_RED;
      end else if (green == mx) begin
         p = blue; n = red; base = BASE_GREEN;
      end else begin
         p = red; n = green; base = BASE_BLUE;
      end
      neg = p < n;
      d = neg ? (n - p) : (p - n);
      hue_num = 14'(d) * 14'(HUE_STEP);

      data_in.sat.rem = {spread, 8'd0} - {8'd0, spread};
      data_in.sat.dvs = {mx, 7'd0};
      data_in.sat.quo = '0;
      data_in.hue.rem = {2'b00, hue_num};
      data_in.hue.dvs = {spread, 7'd0};
      data_in.hue.quo = '0;
      data_in.base = base;
      data_in.neg = neg;
      data_in.grey = (spread == '0);
      data_in.brightness = mx;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

FILE: design/rhsv_cell.sv
// Divider cell: one quotient bit for both saturation and hue per stage.
// Depends on rhsv_pkg.
module rhsv_cell (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  rhsv_pkg::rhsv_work_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output rhsv_pkg::rhsv_work_type out_data
);
   import rhsv_pkg::*;

   logic valid_ff;
   rhsv_work_type data_ff, data_in;

   always_comb begin
      data_in = in_data;
      data_in.sat = rhsv_div_step(in_data.sat);
      data_in.hue = rhsv_div_step(in_data.hue);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

FILE: design/rgb_to_hsv_8bit.sv
// RGB to HSV converter, 8 bits per channel: setup stage, a chain of divider
// cells (one quotient bit each) and a registered output. Depends on rhsv_pkg,
// rhsv_front and rhsv_cell. Stages: setup, 8 divider cells, output register.
// Throughput: one transaction per cycle; every stage has its own valid and
// stalls only when the stage after it is full and held.
// Reset: synchronous, clears all stage valids; no data is cleared.
module rgb_to_hsv_8bit (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [23:0] req_tdata,   // red[7:0], green[15:8], blue[23:16]
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [23:0] rsp_tdata    // hue[7:0], saturation[15:8], brightness[23:16]
);
   import rhsv_pkg::*;

   logic [NUM_CELLS:0] vld;
   logic [NUM_CELLS:0] rdy;
   rhsv_work_type work [NUM_CELLS+1];

   logic rsp_valid_ff;
   logic [CHAN_W-1:0] hue_ff, sat_ff, bright_ff;
   logic [CHAN_W-1:0] hue_in, sat_in;
   rhsv_work_type last;

   rhsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .out_valid (vld[0]),
      .out_ready (rdy[0]),
      .out_data  (work[0])
   );

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      rhsv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[k]),
         .in_ready  (rdy[k]),
         .in_data   (work[k]),
         .out_valid (vld[k+1]),
         .out_ready (rdy[k+1]),
         .out_data  (work[k+1])
      );
   end

   assign last = work[NUM_CELLS];
   assign rdy[NUM_CELLS] = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (last.grey) begin
         hue_in = '0;
         sat_in = '0;
      end else begin
         hue_in = last.neg ? (last.base - last.hue.quo) : (last.base + last.hue.quo);
         sat_in = last.sat.quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rdy[NUM_CELLS]) begin
         rsp_valid_ff <= vld[NUM_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[NUM_CELLS] && vld[NUM_CELLS]) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         bright_ff <= last.brightness;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {bright_ff, sat_ff, hue_ff};

   // zero saturation only for grey pixels, which carry zero hue
   a_grey_hue: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[15:8] == 8'd0) |-> rsp_tdata[7:0] == 8'd0)
      else $error("nonzero hue with zero saturation");

   // hue step quotient never exceeds one sector width
   a_hue_quo: assert property (@(posedge clock) disable iff (reset)
      vld[NUM_CELLS] && !last.grey |-> last.hue.quo <= QUO_W'(HUE_STEP))
      else $error("hue quotient out of range");

   // a black pixel carries zero hue and saturation
   a_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[23:16] == 8'd0) |-> rsp_tdata[15:0] == 16'd0)
      else $error("color on a black pixel");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
